@@ rtl/fcl_pkg.sv @@
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types, constants and the control program of the fully connected layer.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int MAX_DIM_DEF = 64;  // default largest vector length
  localparam int FX_W        = 16;  // fixed-point word width
  localparam int FX_INT      = 9;   // integer bits
  localparam int FX_FRAC     = FX_W - FX_INT;
  localparam int LEN_W       = 7;   // width of the length registers
  localparam int IDX_W       = 6;   // width of the row / col fields
  localparam int PROD_W      = 2 * FX_W;

  // register indexes on the configuration port
  localparam logic REG_IN_LEN  = 1'b0;
  localparam logic REG_OUT_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_INPUT  = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_WEIGHT = 2'd2,
    KIND_RUN    = 2'd3
  } kind_t;

  // program steps
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_ROW  = 3'd1,
    S_BIAS = 3'd2,
    S_RD   = 3'd3,
    S_MUL  = 3'd4,
    S_ACC  = 3'd5,
    S_EMIT = 3'd6,
    S_DONE = 3'd7
  } step_t;

  // hold conditions: the step repeats while it is true
  typedef enum logic [1:0] {
    W_NONE,
    W_START,
    W_OUT
  } wait_t;

  // jump conditions: go to target when true, else to the next step
  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_COLS_ZERO,
    J_COL_MORE,
    J_ROW_MORE
  } jump_t;

  typedef struct packed {
    logic  in_ready;
    logic  start_run;
    logic  clr_col;
    logic  ld_bias;
    logic  ld_prod;
    logic  acc_step;
    logic  emit;
    wait_t wait_c;
    jump_t jump_c;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic out_busy;
    logic cols_zero;
    logic col_more;
    logic row_more;
  } stat_t;

  localparam ctl_t CTL_NOP = '{in_ready: 1'b0, start_run: 1'b0, clr_col: 1'b0,
                               ld_bias: 1'b0, ld_prod: 1'b0, acc_step: 1'b0,
                               emit: 1'b0, wait_c: W_NONE, jump_c: J_NEXT,
                               target: S_IDLE};

  // control store
  function automatic ctl_t rom_word(step_t s);
    ctl_t c;
    c = CTL_NOP;
    unique case (s)
      S_IDLE: begin
        c.in_ready  = 1'b1;
        c.start_run = 1'b1;
        c.wait_c    = W_START;
      end
      S_ROW:  c.clr_col = 1'b1;
      S_BIAS: begin
        c.ld_bias = 1'b1;
        c.jump_c  = J_COLS_ZERO;
        c.target  = S_EMIT;
      end
      S_RD:   c = CTL_NOP;
      S_MUL:  c.ld_prod = 1'b1;
      S_ACC: begin
        c.acc_step = 1'b1;
        c.jump_c   = J_COL_MORE;
        c.target   = S_RD;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.wait_c = W_OUT;
        c.jump_c = J_ROW_MORE;
        c.target = S_ROW;
      end
      S_DONE: begin
        c.jump_c = J_ALWAYS;
        c.target = S_IDLE;
      end
      default: c = CTL_NOP;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/fcl_ram.sv @@
// ----------------------------------------------------------------------------
// fcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fcl_seq.sv @@
// ----------------------------------------------------------------------------
// fcl_seq
// Step counter and control store; issues one control word per cycle, repeating it while the step holds.
// ----------------------------------------------------------------------------
module fcl_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  fcl_pkg::stat_t stat,
  output fcl_pkg::ctl_t  ctl,
  output logic           fire
);
  import fcl_pkg::*;

  step_t pc_r, pc_nxt;
  logic  hold;
  logic  take;

  // output decode
  always_comb begin
    ctl = rom_word(pc_r);
  end

  always_comb begin
    unique case (ctl.wait_c)
      W_START: hold = !stat.start;
      W_OUT:   hold = stat.out_busy;
      default: hold = 1'b0;
    endcase
    unique case (ctl.jump_c)
      J_ALWAYS:    take = 1'b1;
      J_COLS_ZERO: take = stat.cols_zero;
      J_COL_MORE:  take = stat.col_more;
      J_ROW_MORE:  take = stat.row_more;
      default:     take = 1'b0;
    endcase
  end

  assign fire = !hold;

  // next step
  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = step_t'(pc_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ rtl/fully_connected_layer_forward.sv @@
// ----------------------------------------------------------------------------
// fully_connected_layer_forward
// Fixed-point y = W*x + b (16-bit words, 7 fraction bits) run by a microcode.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : item stream. in_tuser is the kind (load input, load bias, load
//           weight, run); in_tdata carries row, col and value.
//   out_* : one item per output row, row order; out_tlast marks the last row.
//   cfg_* : in_len / out_len; the user must write them only while the block is
//           idle, which the block itself does not enforce.
// Input: load items are taken back to back while the sequencer idles. A run
//   holds the input until the program returns to idle: each column is read,
//   multiplied and accumulated in three steps of the control program (one
//   shared multiplier, one registered read port per RAM), plus three per row.
// Reset: lengths return to 1, accumulator to zero, sequencer to idle. The
//   RAMs are not cleared; entries must be written before a run reads them.
// Stall: a result waits in the output register; the emit step holds until
//   that register is free, so nothing is lost. After the last row the block
//   takes new items even while that row still waits.
// ----------------------------------------------------------------------------
module fully_connected_layer_forward #(
  parameter int MAX_DIM = fcl_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [31:0]              in_tdata,   // row[5:0], col[11:6], value[27:12]
  input  logic [1:0]               in_tuser,   // kind[1:0]
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [23:0]              out_tdata,  // out_row[5:0], out_value[21:6]
  output logic                     out_tlast,
  // configuration
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [fcl_pkg::LEN_W-1:0] cfg_wdata
);
  import fcl_pkg::*;

  localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int WD  = MAX_DIM * MAX_DIM;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIM);

  // field unpack
  logic [IDX_W-1:0]       f_row, f_col;
  logic signed [FX_W-1:0] f_value;
  kind_t                  f_kind;

  assign f_row   = in_tdata[5:0];
  assign f_col   = in_tdata[11:6];
  assign f_value = in_tdata[27:12];
  assign f_kind  = kind_t'(in_tuser);

  // config registers
  logic [LEN_W-1:0] in_len_r, out_len_r;
  logic [LEN_W-1:0] rows, cols;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r  <= LEN_W'(1);
      out_len_r <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IN_LEN:  in_len_r  <= cfg_wdata;
        REG_OUT_LEN: out_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lengths above the storage size saturate
  assign rows = (out_len_r > MAX_LEN) ? MAX_LEN : out_len_r;
  assign cols = (in_len_r  > MAX_LEN) ? MAX_LEN : in_len_r;

  // sequencer
  ctl_t  ctl;
  stat_t stat;
  logic  fire;

  logic [LEN_W-1:0] i_r, j_r;
  logic             accept;
  logic             out_valid_r;

  assign in_tready = ctl.in_ready;
  assign accept    = in_tvalid && in_tready;

  assign stat.start     = accept && (f_kind == KIND_RUN) && (rows != '0);
  assign stat.out_busy  = out_valid_r && !out_tready;
  assign stat.cols_zero = (cols == '0);
  assign stat.col_more  = ((j_r + LEN_W'(1)) < cols);
  assign stat.row_more  = ((i_r + LEN_W'(1)) < rows);

  fcl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .fire  (fire)
  );

  // storage: loads write, counters address the reads
  logic row_ok, col_ok;
  logic we_x, we_b, we_w;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic signed [FX_W-1:0] x_q, b_q, w_q;

  assign row_ok = ({1'b0, f_row} < MAX_LEN);
  assign col_ok = ({1'b0, f_col} < MAX_LEN);
  assign we_x   = accept && (f_kind == KIND_INPUT)  && col_ok;
  assign we_b   = accept && (f_kind == KIND_BIAS)   && row_ok;
  assign we_w   = accept && (f_kind == KIND_WEIGHT) && row_ok && col_ok;

  assign w_waddr = WAW'(int'(f_row) * MAX_DIM + int'(f_col));
  assign w_raddr = WAW'(int'(i_r) * MAX_DIM + int'(j_r));

  fcl_ram #(.WIDTH(FX_W), .DEPTH(MAX_DIM)) u_xram (
    .clk   (clk),
    .we    (we_x),
    .waddr (f_col[AW-1:0]),
    .wdata (f_value),
    .raddr (j_r[AW-1:0]),
    .rdata (x_q)
  );

  fcl_ram #(.WIDTH(FX_W), .DEPTH(MAX_DIM)) u_bram (
    .clk   (clk),
    .we    (we_b),
    .waddr (f_row[AW-1:0]),
    .wdata (f_value),
    .raddr (i_r[AW-1:0]),
    .rdata (b_q)
  );

  fcl_ram #(.WIDTH(FX_W), .DEPTH(WD)) u_wram (
    .clk   (clk),
    .we    (we_w),
    .waddr (w_waddr),
    .wdata (f_value),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  // datapath
  logic signed [PROD_W-1:0] prod_r;
  logic [FX_W-1:0]          acc_r, acc_nxt;

  // floor(p / 2^FX_FRAC) keeps bits above the fraction; wrap to the word width
  assign acc_nxt = acc_r + prod_r[FX_FRAC +: FX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r   <= '0;
      j_r   <= '0;
      acc_r <= '0;
    end else if (fire) begin
      if (ctl.start_run) i_r   <= '0;
      if (ctl.clr_col)   j_r   <= '0;
      if (ctl.ld_bias)   acc_r <= b_q;
      if (ctl.acc_step) begin
        acc_r <= acc_nxt;
        j_r   <= j_r + LEN_W'(1);
      end
      if (ctl.emit)      i_r   <= i_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.ld_prod) begin
      prod_r <= w_q * x_q;
    end
  end

  // output register
  logic [IDX_W-1:0] out_row_r;
  logic [FX_W-1:0]  out_value_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.emit) begin
      out_row_r   <= i_r[IDX_W-1:0];
      out_value_r <= acc_r;
      out_last_r  <= !stat.row_more;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_value_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point fully connected layer.
// A driver feeds load and run items from a queue, and a bit-accurate predictor
// of y = W*x + b gives the rows that each run must emit. A monitor compares
// each emitted row with the oldest prediction. Both streams idle at random outside no_idle phases.
// The lengths are changed only while the block is quiet. Every entry is
// loaded before a run reads it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcl_pkg::*;

  localparam int DIM        = MAX_DIM_DEF;
  localparam int QUIET_CYC  = 4 * DIM + 16;  // after-run slack; > one row of the widest run
  localparam int CYCLE_CAP  = 400000;        // run-away guard

  typedef struct {
    kind_t              kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [FX_W-1:0]    value;
    bit                 drain;  // hold this item until no row is pending
  } fc_item_t;

  typedef struct {
    logic [IDX_W-1:0]   row;
    logic [FX_W-1:0]    value;
    logic               last;
  } y_row_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // DUT ports; the inputs that the bench drives are known from time zero
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;
  logic [1:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [23:0]      out_tdata;
  logic             out_tlast;
  logic             cfg_we     = 1'b0;
  logic             cfg_addr   = 1'b0;
  logic [LEN_W-1:0] cfg_wdata  = '0;

  fully_connected_layer_forward u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // row[5:0], col[11:6], value[27:12]
    .in_tuser   (in_tuser),   // kind[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_row[5:0], out_value[21:6]
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // shared bench state
  // --------------------------------------------------------------------------
  fc_item_t    load_q[$];      // items waiting for the driver
  y_row_t      y_expect[$];    // predicted rows, oldest first
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_err      = 0;
  int unsigned n_cycles   = 0;
  bit          no_idle    = 1'b0;  // phase without gaps on either side

  // predictor copy of the layer
  logic [FX_W-1:0]  x_vec [DIM];
  logic [FX_W-1:0]  b_vec [DIM];
  logic [FX_W-1:0]  w_mat [DIM][DIM];
  logic [LEN_W-1:0] cols_reg = 7'd1;
  logic [LEN_W-1:0] rows_reg = 7'd1;

  // what the stimulus has already loaded (never read an unloaded entry)
  bit gen_x [DIM];
  bit gen_b [DIM];
  bit gen_w [DIM][DIM];

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // predictor: update the layer copy, queue the rows a run emits
  // --------------------------------------------------------------------------
  task automatic forward_item(input fc_item_t it);
    int                  nr;
    int                  nc;
    int                  i;
    int                  j;
    logic [FX_W-1:0]     acc;
    logic signed [31:0]  prod;
    y_row_t              yr;
    case (it.kind)
      KIND_INPUT:  x_vec[it.col] = it.value;
      KIND_BIAS:   b_vec[it.row] = it.value;
      KIND_WEIGHT: w_mat[it.row][it.col] = it.value;
      default: begin
        // lengths above the array size saturate; zero is legal
        nr = (rows_reg > DIM) ? DIM : int'(rows_reg);
        nc = (cols_reg > DIM) ? DIM : int'(cols_reg);
        for (i = 0; i < nr; i++) begin
          acc = b_vec[i];
          for (j = 0; j < nc; j++) begin
            prod = $signed(w_mat[i][j]) * $signed(x_vec[j]);
            // arithmetic shift by the fraction bits, then 16-bit wrap
            acc  = acc + prod[FX_FRAC+FX_W-1:FX_FRAC];
          end
          yr.row   = i[IDX_W-1:0];
          yr.value = acc;
          yr.last  = (i == nr - 1);
          y_expect.push_back(yr);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // driver: one item at a time from load_q, random gaps between items
  // --------------------------------------------------------------------------
  fc_item_t    cur_item;
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        // accepted at this edge
        forward_item(cur_item);
        n_accepted++;
      end
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (load_q.size() != 0 &&
                   !(load_q[0].drain && y_expect.size() != 0)) begin
        cur_item = load_q.pop_front();
        in_tdata <= {4'b0, cur_item.value, cur_item.col, cur_item.row};
        in_tuser <= cur_item.kind;
        nv = 1'b1;
        in_gap = no_idle ? 0 : draw_gap();
      end
      in_tvalid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check each emitted row, stall the result side at random
  // --------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk) begin
    y_row_t want;
    logic   rdy;
    if (rst_n && out_tvalid && out_tready) begin
      if (y_expect.size() == 0) begin
        $error("unexpected row: out_row %0d out_value %0d", out_tdata[5:0],
               $signed(out_tdata[21:6]));
        n_err++;
      end else begin
        want = y_expect.pop_front();
        if (out_tdata[5:0] !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_tdata[5:0]);
          n_err++;
        end
        if (out_tdata[21:6] !== want.value) begin
          $error("out_value: expected %0d, got %0d", $signed(want.value),
                 $signed(out_tdata[21:6]));
          n_err++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          n_err++;
        end
      end
    end
    rdy = 1'b1;
    if (out_stall > 0) begin
      rdy = 1'b0;
      out_stall--;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      rdy = 1'b0;
      out_stall = draw_gap();
    end
    out_tready <= rdy;
  end

  // hard stop
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(input kind_t k, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [FX_W-1:0] v,
                           input bit d);
    fc_item_t it;
    it.kind  = k;
    it.row   = r;
    it.col   = c;
    it.value = v;
    it.drain = d;
    case (k)
      KIND_INPUT:  gen_x[c] = 1'b1;
      KIND_BIAS:   gen_b[r] = 1'b1;
      KIND_WEIGHT: gen_w[r][c] = 1'b1;
      default: ;
    endcase
    load_q.push_back(it);
    n_queued++;
  endtask

  // extremes, small magnitudes (no wrap) and full-range values
  function automatic logic [FX_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4, 5:    return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // stray loads anywhere, unrelated to the next run
  task automatic add_noise(input int unsigned n);
    repeat (n)
      push_item(kind_t'($urandom_range(0, 2)), 6'($urandom), 6'($urandom),
                pick_value(), 1'b0);
  endtask

  // load what the next run reads and is not yet loaded (and refresh some of it), then run
  task automatic prepare_run(input int cols, input int rows);
    fc_item_t batch[$];
    fc_item_t it;
    fc_item_t tmp;
    int       nr;
    int       nc;
    int       i;
    int       j;
    int       k;
    nr = (rows > DIM) ? DIM : rows;
    nc = (cols > DIM) ? DIM : cols;
    it.drain = 1'b0;
    for (j = 0; j < nc; j++)
      if (!gen_x[j] || $urandom_range(0, 3) == 0) begin
        it.kind = KIND_INPUT; it.row = 6'($urandom); it.col = j[5:0];
        it.value = pick_value();
        batch.push_back(it);
      end
    for (i = 0; i < nr; i++)
      if (!gen_b[i] || $urandom_range(0, 3) == 0) begin
        it.kind = KIND_BIAS; it.row = i[5:0]; it.col = 6'($urandom);
        it.value = pick_value();
        batch.push_back(it);
      end
    for (i = 0; i < nr; i++)
      for (j = 0; j < nc; j++)
        if (!gen_w[i][j] || $urandom_range(0, 3) == 0) begin
          it.kind = KIND_WEIGHT; it.row = i[5:0]; it.col = j[5:0];
          it.value = pick_value();
          batch.push_back(it);
        end
    // shuffle so the load kinds interleave
    for (k = batch.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = batch[k]; batch[k] = batch[j]; batch[j] = tmp;
    end
    foreach (batch[k])
      push_item(batch[k].kind, batch[k].row, batch[k].col, batch[k].value, 1'b0);
    // row, col and value are don't-care on a run
    push_item(KIND_RUN, 6'($urandom), 6'($urandom), 16'($urandom),
              $urandom_range(0, 4) == 0);
  endtask

  // wait until every item is taken and every row is out, then let the
  // sequencer finish whatever it may still be doing
  task automatic settle();
    while (n_accepted != n_queued || y_expect.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [LEN_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IN_LEN)
      cols_reg = val;
    else
      rows_reg = val;
  endtask

  task automatic run_phase(input int cols, input int rows, input int runs);
    settle();
    cfg_write(REG_IN_LEN, cols[LEN_W-1:0]);
    cfg_write(REG_OUT_LEN, rows[LEN_W-1:0]);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (runs) begin
      add_noise($urandom_range(0, 4));
      prepare_run(cols, rows);
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int          k;
    foreach (x_vec[k]) begin
      x_vec[k] = '0;
      b_vec[k] = '0;
      gen_x[k] = 1'b0;
      gen_b[k] = 1'b0;
    end
    foreach (w_mat[k, j]) begin
      w_mat[k][j] = '0;
      gen_w[k][j] = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, on the reset lengths (one column, one row)
    // max * max on a min bias: wraps
    push_item(KIND_INPUT,  6'd63, 6'd0,  16'h7fff, 1'b0);
    push_item(KIND_BIAS,   6'd0,  6'd63, 16'h8000, 1'b0);
    push_item(KIND_WEIGHT, 6'd0,  6'd0,  16'h7fff, 1'b0);
    push_item(KIND_RUN,    6'd63, 6'd63, 16'hffff, 1'b0);
    // min * min: largest product
    push_item(KIND_WEIGHT, 6'd0,  6'd0,  16'h8000, 1'b0);
    push_item(KIND_INPUT,  6'd0,  6'd0,  16'h8000, 1'b0);
    push_item(KIND_BIAS,   6'd0,  6'd0,  16'h7fff, 1'b0);
    push_item(KIND_RUN,    6'd0,  6'd0,  16'h0000, 1'b0);
    // small negative product: shift rounds toward minus infinity
    push_item(KIND_INPUT,  6'd0,  6'd0,  16'hffff, 1'b0);
    push_item(KIND_WEIGHT, 6'd0,  6'd0,  16'h0001, 1'b0);
    push_item(KIND_BIAS,   6'd0,  6'd0,  16'h0000, 1'b0);
    push_item(KIND_RUN,    6'd0,  6'd0,  16'h0000, 1'b0);
    // top indexes, unused by a one-by-one run
    push_item(KIND_WEIGHT, 6'd63, 6'd63, 16'h5a5a, 1'b0);
    push_item(KIND_INPUT,  6'd0,  6'd63, 16'ha5a5, 1'b0);
    push_item(KIND_BIAS,   6'd63, 6'd0,  16'h0180, 1'b0);
    push_item(KIND_WEIGHT, 6'd0,  6'd63, 16'hff80, 1'b0);
    push_item(KIND_WEIGHT, 6'd63, 6'd0,  16'h0080, 1'b0);
    // run held back until the result side has drained
    push_item(KIND_RUN,    6'd21, 6'd42, 16'h1234, 1'b1);

    // length corner cases
    run_phase(0,   127, 1);   // no columns, rows saturate: rows equal the bias
    run_phase(5,   0,   1);   // no rows: nothing emitted
    run_phase(1,   1,   1);

    // random small shapes
    for (k = 0; k < 3 || n_queued < 150; k++)
      run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 2));

    settle();
    if (n_err == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
